// ===== design/hrclf_pkg.sv =====
// ----------------------------------------------------------------------------
// hrclf_pkg
// Shared types and constants of the content-length response framer.
// ----------------------------------------------------------------------------
package hrclf_pkg;

	localparam int DataW    = 8;
	localparam int LenW     = 31;
	localparam int CntW     = 16;
	localparam int StatusW  = 3;
	localparam int OutDataW = 56;

	localparam logic [CntW-1:0] MaxHdrReset = 16'd8192;
	localparam logic [CntW-1:0] MinHeader   = 16'd10;
	localparam logic [CntW-1:0] CntSat      = 16'hFFFF;
	localparam logic [LenW-1:0] LenLimit    = 31'h7FFF_FFFF;
	localparam logic [3:0]      KeyLen      = 4'd15;

	localparam logic [DataW-1:0] ChCr       = 8'h0D;
	localparam logic [DataW-1:0] ChLf       = 8'h0A;
	localparam logic [DataW-1:0] ChSp       = 8'h20;
	localparam logic [DataW-1:0] ChZero     = 8'h30;
	localparam logic [DataW-1:0] ChNine     = 8'h39;
	localparam logic [DataW-1:0] ChKeyFirst = 8'h43;

	typedef enum logic [StatusW-1:0] {
		ST_WAIT      = 3'd0,
		ST_HDR_DONE  = 3'd1,
		ST_COMPLETE  = 3'd2,
		ST_TOO_BIG   = 3'd3,
		ST_TOO_SMALL = 3'd4,
		ST_NO_LEN    = 3'd5,
		ST_BAD_LEN   = 3'd6
	} hrclf_status_t;

	typedef struct packed {
		hrclf_status_t   status;
		logic [LenW-1:0] content_length;
		logic [CntW-1:0] header_bytes;
	} hrclf_result_t;

	// "Content-Length:" one character per index
	function automatic logic [DataW-1:0] key_char(input logic [3:0] idx);
		logic [DataW-1:0] c;
		unique case (idx)
			4'd0:    c = 8'h43;
			4'd1:    c = 8'h6F;
			4'd2:    c = 8'h6E;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2D;
			4'd8:    c = 8'h4C;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6E;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			4'd14:   c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== design/hrclf_parse.sv =====
// ----------------------------------------------------------------------------
// hrclf_parse
// Per-byte message state and result logic; state advances on each step.
// ----------------------------------------------------------------------------
module hrclf_parse (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step_en,
	input  logic [hrclf_pkg::DataW-1:0]    data_byte,
	input  logic [hrclf_pkg::CntW-1:0]     max_header_bytes,
	output hrclf_pkg::hrclf_result_t       result
);

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_HEADER,
		PH_BODY
	} phase_t;

	typedef enum logic [2:0] {
		VP_SEARCH,
		VP_COLON,
		VP_SPACE,
		VP_DIGITS,
		VP_WANT_LF,
		VP_DONE
	} vphase_t;

	phase_t                         phase_q, phase_n;
	vphase_t                        vphase_q, vphase_n;
	logic [hrclf_pkg::CntW-1:0]     hdr_cnt_q, hdr_cnt_n;
	logic [1:0]                     term_q, term_n;
	logic [3:0]                     key_q, key_n;
	logic [hrclf_pkg::LenW-1:0]     len_q, len_n;
	logic                           bad_q, bad_n;
	logic [hrclf_pkg::LenW-1:0]     remain_q, remain_n;
	logic [hrclf_pkg::LenW+3:0]     prod;
	logic                           term_done;
	logic                           clear_msg;
	hrclf_pkg::hrclf_result_t       res;

	always_comb begin
		phase_n   = phase_q;
		vphase_n  = vphase_q;
		hdr_cnt_n = hdr_cnt_q;
		term_n    = term_q;
		key_n     = key_q;
		len_n     = len_q;
		bad_n     = bad_q;
		remain_n  = remain_q;
		term_done = 1'b0;
		clear_msg = 1'b0;
		prod      = ({4'b0, len_q} << 3) + ({4'b0, len_q} << 1)
			+ {27'b0, data_byte - hrclf_pkg::ChZero};
		res.status         = hrclf_pkg::ST_WAIT;
		res.content_length = '0;
		res.header_bytes   = '0;

		if (phase_q == PH_SKIP &&
				(data_byte == hrclf_pkg::ChCr || data_byte == hrclf_pkg::ChLf)) begin
			// leading line break dropped
		end else if (phase_q == PH_BODY) begin
			res.content_length = len_q;
			res.header_bytes   = hdr_cnt_q;
			remain_n = (remain_q != '0) ? remain_q - 1'b1 : remain_q;
			if (remain_n == '0) begin
				res.status = hrclf_pkg::ST_COMPLETE;
				clear_msg  = 1'b1;
			end
		end else begin
			phase_n = PH_HEADER;

			// value parse
			unique case (vphase_q) inside
				VP_SEARCH: begin
					if (key_q < hrclf_pkg::KeyLen &&
							data_byte == hrclf_pkg::key_char(key_q)) begin
						if (key_q + 4'd1 == hrclf_pkg::KeyLen) begin
							vphase_n = VP_COLON;
							key_n    = '0;
						end else begin
							key_n = key_q + 4'd1;
						end
					end else begin
						key_n = (data_byte == hrclf_pkg::ChKeyFirst) ? 4'd1 : 4'd0;
					end
				end
				VP_DONE: begin
				end
				VP_WANT_LF: begin
					if (data_byte != hrclf_pkg::ChLf)
						bad_n = 1'b1;
					vphase_n = VP_DONE;
				end
				VP_COLON, VP_SPACE, VP_DIGITS: begin
					if (vphase_q == VP_COLON && data_byte == hrclf_pkg::ChSp) begin
						vphase_n = VP_SPACE;
					end else if (data_byte >= hrclf_pkg::ChZero &&
							data_byte <= hrclf_pkg::ChNine) begin
						len_n    = (|prod[hrclf_pkg::LenW+3:hrclf_pkg::LenW]) ?
							hrclf_pkg::LenLimit : prod[hrclf_pkg::LenW-1:0];
						vphase_n = VP_DIGITS;
					end else if (data_byte == hrclf_pkg::ChCr) begin
						vphase_n = VP_WANT_LF;
					end else begin
						bad_n    = 1'b1;
						vphase_n = VP_DONE;
					end
				end
				default: begin
				end
			endcase

			// blank line search
			if (data_byte == hrclf_pkg::ChCr) begin
				term_n = (term_q == 2'd2) ? 2'd3 : 2'd1;
			end else if (data_byte == hrclf_pkg::ChLf && (term_q == 2'd1 || term_q == 2'd3)) begin
				if (term_q == 2'd3) begin
					term_done = 1'b1;
					term_n    = 2'd0;
				end else begin
					term_n = 2'd2;
				end
			end else begin
				term_n = 2'd0;
			end

			hdr_cnt_n = (hdr_cnt_q != hrclf_pkg::CntSat) ? hdr_cnt_q + 1'b1 : hdr_cnt_q;
			res.header_bytes = hdr_cnt_n;

			if (term_done) begin
				if (hdr_cnt_n < hrclf_pkg::MinHeader) begin
					res.status = hrclf_pkg::ST_TOO_SMALL;
				end else if (vphase_n == VP_SEARCH) begin
					res.status = hrclf_pkg::ST_NO_LEN;
				end else if (bad_n || vphase_n != VP_DONE || len_n == hrclf_pkg::LenLimit) begin
					res.status = hrclf_pkg::ST_BAD_LEN;
				end else begin
					res.content_length = len_n;
					if (len_n == '0) begin
						res.status = hrclf_pkg::ST_COMPLETE;
					end else begin
						res.status = hrclf_pkg::ST_HDR_DONE;
						phase_n    = PH_BODY;
						remain_n   = len_n;
					end
				end
				clear_msg = (res.status != hrclf_pkg::ST_HDR_DONE);
			end else if (hdr_cnt_n >= max_header_bytes) begin
				res.status = hrclf_pkg::ST_TOO_BIG;
				clear_msg  = 1'b1;
			end
		end

		if (clear_msg) begin
			phase_n   = PH_SKIP;
			vphase_n  = VP_SEARCH;
			hdr_cnt_n = '0;
			term_n    = '0;
			key_n     = '0;
			len_n     = '0;
			bad_n     = 1'b0;
			remain_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SKIP;
			vphase_q  <= VP_SEARCH;
			hdr_cnt_q <= '0;
			term_q    <= '0;
			key_q     <= '0;
			len_q     <= '0;
			bad_q     <= 1'b0;
			remain_q  <= '0;
		end else if (step_en) begin
			phase_q   <= phase_n;
			vphase_q  <= vphase_n;
			hdr_cnt_q <= hdr_cnt_n;
			term_q    <= term_n;
			key_q     <= key_n;
			len_q     <= len_n;
			bad_q     <= bad_n;
			remain_q  <= remain_n;
		end
	end

	assign result = res;

endmodule

// ===== design/http_response_content_length_framer.sv =====
// ----------------------------------------------------------------------------
// http_response_content_length_framer
// Frames a response byte stream by its header and content-length body.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the result side accepts, and each
// byte gives exactly one result transfer: the byte sits in an input
// register, the parse step runs between it and the result register, and the
// result register holds a finished result while the next byte is already
// taken. Sustained rate is one byte per cycle while the result side accepts.
// Status codes: 0 wait, 1 header done, 2 message complete, 3 too big,
// 4 too small, 5 no length, 6 bad length; a new message starts after any
// status other than 0 and 1.
module http_response_content_length_framer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,   // data_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [hrclf_pkg::OutDataW-1:0]  m_axis_tdata,   // status, content_length, header_bytes, zero pad
	input  logic                            cfg_wr_en,
	input  logic [hrclf_pkg::CntW-1:0]      cfg_wr_data     // max_header_bytes
);

	logic                           in_valid_s1;
	logic [hrclf_pkg::DataW-1:0]    in_data_s1;
	logic                           out_valid_q;
	logic [hrclf_pkg::OutDataW-1:0] out_data_q;
	logic [hrclf_pkg::CntW-1:0]     max_hdr_q;
	logic                           advance;
	logic                           step_en;
	hrclf_pkg::hrclf_result_t       result;

	assign advance       = !out_valid_q || m_axis_tready;
	assign step_en       = in_valid_s1 && advance;
	assign s_axis_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q <= hrclf_pkg::MaxHdrReset;
		end else if (cfg_wr_en) begin
			max_hdr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			in_data_s1 <= s_axis_tdata;
	end

	hrclf_parse u_parse (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_en          (step_en),
		.data_byte        (in_data_s1),
		.max_header_bytes (max_hdr_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en)
			out_data_q <= {6'b0, result.header_bytes, result.content_length, result.status};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/hrclf_checker.sv =====
// ----------------------------------------------------------------------------
// hrclf_checker
// Port-level checks of the content-length framer, bound to the top level.
// ----------------------------------------------------------------------------
module hrclf_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [hrclf_pkg::OutDataW-1:0]  m_axis_tdata
);

	logic [2:0]  st;
	logic [30:0] clen;
	logic [15:0] hbytes;

	assign st     = m_axis_tdata[2:0];
	assign clen   = m_axis_tdata[33:3];
	assign hbytes = m_axis_tdata[49:34];

	// stalled result transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_too_small: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == hrclf_pkg::ST_TOO_SMALL |-> hbytes < hrclf_pkg::MinHeader)
		else $error("too small reported on a long header");

	a_hdr_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st == hrclf_pkg::ST_HDR_DONE |->
			clen != '0 && clen != hrclf_pkg::LenLimit && hbytes >= hrclf_pkg::MinHeader)
		else $error("header done with unusable length");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (st == hrclf_pkg::ST_TOO_BIG || st == hrclf_pkg::ST_TOO_SMALL ||
			st == hrclf_pkg::ST_NO_LEN || st == hrclf_pkg::ST_BAD_LEN) |-> clen == '0)
		else $error("length shown with an error status");

endmodule

bind http_response_content_length_framer hrclf_checker u_hrclf_checker (.*);

// ===== sim/framer_result_checker.sv =====
// ----------------------------------------------------------------------------
// framer_result_checker
// Watches the byte, result and register ports of the content-length framer,
// works out the result of every accepted byte with its own copy of the
// parser state, and compares each result transfer field by field with the
// oldest outstanding prediction. Mismatch and outstanding counts go to the
// testbench top.
// ----------------------------------------------------------------------------
module framer_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [hrclf_pkg::DataW-1:0]    s_axis_tdata,   // data_byte
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [hrclf_pkg::OutDataW-1:0] m_axis_tdata,   // status, content_length, header_bytes, zero pad
	input  logic                           cfg_wr_en,
	input  logic [hrclf_pkg::CntW-1:0]     cfg_wr_data,    // max_header_bytes
	output int                             fail_count,
	output int                             pending
);
	import hrclf_pkg::*;

	typedef enum logic [1:0] {
		MSG_SKIP,
		MSG_HEADER,
		MSG_BODY
	} msg_phase_t;

	typedef enum logic [2:0] {
		VAL_SEARCH,
		VAL_COLON,
		VAL_SPACE,
		VAL_DIGITS,
		VAL_WANT_LF,
		VAL_DONE
	} val_phase_t;

	localparam logic [8*15-1:0] KeyText = "Content-Length:";

	logic [CntW-1:0] max_hdr;
	msg_phase_t      msg_phase;
	logic [CntW-1:0] hdr_count;
	logic [1:0]      term_prog;
	logic [3:0]      key_prog;
	val_phase_t      val_phase;
	logic [LenW-1:0] len_value;
	logic            len_bad;
	logic [LenW-1:0] body_left;

	hrclf_result_t expected_results[$];
	int            mismatches;

	task automatic restart_message();
		msg_phase = MSG_SKIP;
		hdr_count = '0;
		term_prog = '0;
		key_prog  = '0;
		val_phase = VAL_SEARCH;
		len_value = '0;
		len_bad   = 1'b0;
		body_left = '0;
	endtask

	// key search, then optional space, digits and the closing line break
	task automatic track_length_field(input logic [7:0] b);
		logic [3:0]  k;
		logic [63:0] acc;
		if (val_phase == VAL_SEARCH) begin
			k = key_prog;
			if (k < KeyLen && b == KeyText[8 * (14 - int'(k)) +: 8]) begin
				k = k + 4'd1;
				if (k == KeyLen) begin
					val_phase = VAL_COLON;
					k = '0;
				end
			end else begin
				k = (b == ChKeyFirst) ? 4'd1 : 4'd0;
			end
			key_prog = k;
		end else if (val_phase == VAL_WANT_LF) begin
			if (b != ChLf)
				len_bad = 1'b1;
			val_phase = VAL_DONE;
		end else if (val_phase != VAL_DONE) begin
			if (val_phase == VAL_COLON && b == ChSp) begin
				val_phase = VAL_SPACE;
			end else if (b >= ChZero && b <= ChNine) begin
				acc = {33'd0, len_value} * 64'd10 + {56'd0, b - ChZero};
				if (acc > {33'd0, LenLimit})
					acc = {33'd0, LenLimit};
				len_value = acc[LenW-1:0];
				val_phase = VAL_DIGITS;
			end else if (b == ChCr) begin
				val_phase = VAL_WANT_LF;
			end else begin
				len_bad   = 1'b1;
				val_phase = VAL_DONE;
			end
		end
	endtask

	task automatic track_terminator(input logic [7:0] b, output logic done);
		done = 1'b0;
		if (b == ChCr) begin
			term_prog = (term_prog == 2'd2) ? 2'd3 : 2'd1;
		end else if (b == ChLf && (term_prog == 2'd1 || term_prog == 2'd3)) begin
			if (term_prog == 2'd3) begin
				done      = 1'b1;
				term_prog = 2'd0;
			end else begin
				term_prog = 2'd2;
			end
		end else begin
			term_prog = 2'd0;
		end
	endtask

	task automatic frame_next_byte(input logic [7:0] b, output hrclf_result_t r);
		hrclf_status_t   st;
		logic [LenW-1:0] clen;
		logic [CntW-1:0] hb;
		logic            done;
		logic            skipped;
		st      = ST_WAIT;
		clen    = '0;
		hb      = '0;
		skipped = 1'b0;
		if (msg_phase == MSG_SKIP) begin
			if (b == ChCr || b == ChLf)
				skipped = 1'b1;
			else
				msg_phase = MSG_HEADER;
		end
		if (!skipped) begin
			if (msg_phase == MSG_BODY) begin
				clen = len_value;
				hb   = hdr_count;
				if (body_left != '0)
					body_left--;
				if (body_left == '0) begin
					st = ST_COMPLETE;
					restart_message();
				end
			end else begin
				track_length_field(b);
				track_terminator(b, done);
				if (hdr_count < CntSat)
					hdr_count++;
				hb = hdr_count;
				if (done) begin
					if (hdr_count < MinHeader) begin
						st = ST_TOO_SMALL;
					end else if (val_phase == VAL_SEARCH) begin
						st = ST_NO_LEN;
					end else if (len_bad || val_phase != VAL_DONE || len_value >= LenLimit) begin
						st = ST_BAD_LEN;
					end else begin
						clen = len_value;
						if (len_value == '0) begin
							st = ST_COMPLETE;
						end else begin
							st        = ST_HDR_DONE;
							msg_phase = MSG_BODY;
							body_left = len_value;
						end
					end
					if (st != ST_HDR_DONE)
						restart_message();
				end else if (hdr_count >= max_hdr) begin
					st = ST_TOO_BIG;
					restart_message();
				end
			end
		end
		r.status         = st;
		r.content_length = clen;
		r.header_bytes   = hb;
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] want_v,
			input logic [63:0] got_v);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		hrclf_result_t   predicted;
		logic [2:0]      got_status;
		logic [LenW-1:0] got_len;
		logic [CntW-1:0] got_hdr;
		logic [5:0]      got_pad;
		if (!arst_n) begin
			max_hdr = MaxHdrReset;
			restart_message();
			expected_results.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en)
				max_hdr = cfg_wr_data;
			if (m_axis_tvalid && m_axis_tready) begin
				got_status = m_axis_tdata[2:0];
				got_len    = m_axis_tdata[33:3];
				got_hdr    = m_axis_tdata[49:34];
				got_pad    = m_axis_tdata[55:50];
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result transfer with none expected, expected nothing, actual %h",
						$time, m_axis_tdata);
				end else begin
					predicted = expected_results.pop_front();
					if (got_status !== predicted.status)
						note_mismatch("status", 64'(predicted.status), 64'(got_status));
					if (got_len !== predicted.content_length)
						note_mismatch("content_length", 64'(predicted.content_length), 64'(got_len));
					if (got_hdr !== predicted.header_bytes)
						note_mismatch("header_bytes", 64'(predicted.header_bytes), 64'(got_hdr));
					if (got_pad !== 6'd0)
						note_mismatch("padding", 64'd0, 64'(got_pad));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				frame_next_byte(s_axis_tdata, predicted);
				expected_results.push_back(predicted);
			end
			fail_count <= mismatches;
			pending    <= expected_results.size();
		end
	end

endmodule

// ===== sim/http_response_content_length_framer_tb.sv =====
// ----------------------------------------------------------------------------
// http_response_content_length_framer_tb
// Drives response byte streams into the content-length framer: directed
// headers for the edge cases of key matching, value parsing and header end
// ordering, then randomised well-formed and broken messages under several
// header size limits. Both stream sides idle at random, and the result side
// holds off for long stretches so that the framer stalls its input. The
// checker beside the framer predicts and compares every result.
// ----------------------------------------------------------------------------
module http_response_content_length_framer_tb;
	import hrclf_pkg::*;

	localparam int StallLimit = 4000;
	localparam int HoldCycles = 300;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [DataW-1:0]    s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                cfg_wr_en;
	logic [CntW-1:0]     cfg_wr_data;

	int         fail_count;
	int         pending;
	bit         quiet;
	int         hold_requests;
	int         bytes_sent;
	logic [7:0] msg_bytes[$];

	http_response_content_length_framer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	framer_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random idling, plus long hold-offs on request
	initial begin : receiver
		int holds_served;
		int hold_left;
		holds_served  = 0;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left    = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(0, 99) >= 9);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < StallLimit) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, StallLimit);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic add_byte(input logic [7:0] b);
		msg_bytes.push_back(b);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endtask

	task automatic add_crlf();
		add_byte(ChCr);
		add_byte(ChLf);
	endtask

	task automatic add_line(input string s);
		add_text(s);
		add_crlf();
	endtask

	task automatic add_random_bytes(input int n);
		int unsigned r;
		repeat (n) begin
			r = $urandom;
			add_byte(r[7:0]);
		end
	endtask

	task automatic add_random_line();
		int unsigned r;
		repeat ($urandom_range(1, 8)) begin
			r = $urandom_range(32, 126);
			add_byte(($urandom_range(0, 4) == 0) ? ChKeyFirst : r[7:0]);
		end
		add_crlf();
	endtask

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_message();
		foreach (msg_bytes[i])
			send_byte(msg_bytes[i]);
		msg_bytes.delete();
	endtask

	task automatic send_header(input string line);
		add_line(line);
		add_crlf();
		send_message();
	endtask

	// stop offering and let every outstanding result come out
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max_header(input logic [CntW-1:0] v);
		drain();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic build_random_message();
		int unsigned sel;
		int unsigned v;
		int unsigned body_len;
		body_len = 0;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			add_random_bytes($urandom_range(1, 24));
			return;
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2))
				add_byte(($urandom_range(0, 1) != 0) ? ChCr : ChLf);
		if ($urandom_range(0, 3) == 0)
			add_line("HTTP/1.1 200 OK");
		repeat ($urandom_range(0, 2)) add_random_line();
		if ($urandom_range(0, 99) < 88) begin
			sel = $urandom_range(0, 99);
			if (sel < 90)
				add_text("Content-Length:");
			else if (sel < 95)
				add_text("content-length:");
			else
				add_text("Content-Lenght:");
			if ($urandom_range(0, 1) != 0)
				add_byte(ChSp);
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				v = $urandom_range(0, 12);
				add_text($sformatf("%0d", v));
				body_len = v;
			end else if (sel < 66) begin
				body_len = 0;
			end else if (sel < 72) begin
				add_text("2147483647");
				body_len = $urandom_range(0, 3);
			end else if (sel < 78) begin
				add_text("99999999999");
				body_len = $urandom_range(0, 3);
			end else if (sel < 86) begin
				v = $urandom_range(13, 40);
				add_text($sformatf("%0d", v));
				body_len = v;
			end else begin
				add_text($sformatf("%0d", $urandom_range(0, 9)));
				case ($urandom_range(0, 4))
					0: add_byte(ChSp);
					1: add_text("-");
					2: add_text("+");
					3: add_text("x");
					default: add_byte(8'h00);
				endcase
				add_text("7");
				body_len = $urandom_range(0, 3);
			end
			if ($urandom_range(0, 19) == 0) begin
				add_byte(ChCr);
				add_text("Z");
			end
			add_crlf();
		end else begin
			body_len = $urandom_range(0, 3);
		end
		repeat ($urandom_range(0, 1)) add_random_line();
		add_crlf();
		add_random_bytes(body_len);
	endtask

	task automatic send_random_traffic(input int target, input bit with_hold);
		int start;
		bit held;
		start = bytes_sent;
		held  = 1'b0;
		while (bytes_sent - start < target) begin
			build_random_message();
			send_message();
			if (with_hold && !held && bytes_sent - start > target / 3) begin
				hold_requests++;
				held = 1'b1;
			end
		end
	endtask

	initial begin : stimulus
		int unsigned r;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		arst_n        = 1'b0;
		quiet         = 1'b0;
		hold_requests = 0;
		bytes_sent    = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// leading line breaks, then a short body with extreme byte values
		add_byte(ChCr);
		add_byte(ChLf);
		add_byte(ChLf);
		add_line("Content-Length: 3");
		add_crlf();
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(8'h55);
		send_message();
		// empty values give a zero body
		send_header("Content-Length:");
		send_header("Content-Length: ");
		// broken values
		send_header("Content-Length:  5");
		send_header("Content-Length:-5");
		send_header("Content-Length:+5");
		send_header("Content-Length:5x");
		send_header("Content-Length:2147483647");
		send_header("Content-Length:99999999999");
		add_text("Content-Length:5");
		add_byte(ChCr);
		add_text("X");
		add_crlf();
		add_crlf();
		send_message();
		// header end ordering around the minimum size
		send_header("X");
		send_header("Ab: c");
		send_header("Abc: d");
		send_header("content-length: 4");
		// only the first key counts
		add_line("Content-Length:2");
		add_line("Content-Length:9");
		add_crlf();
		add_random_bytes(2);
		send_message();
		// key restart on a repeated first letter
		add_line("CContent-Length:1");
		add_crlf();
		add_byte(8'h00);
		send_message();
		// zero bytes inside the header
		add_byte(8'h00);
		add_line("Content-Length:1");
		add_crlf();
		add_byte(8'hAA);
		send_message();
		// stray carriage return inside the terminator
		add_line("Content-Length:1");
		add_byte(ChCr);
		add_crlf();
		add_crlf();
		add_byte(ChCr);
		send_message();
		add_line("Content-Length: 0002");
		add_crlf();
		add_random_bytes(2);
		send_message();

		// limit of 16: terminator wins over the size check on the same byte
		set_max_header(16'd16);
		send_header("Content-Length:0");
		send_header("Abc: d");
		send_header("abcdefghijkl");
		add_line("0123456789ABCDEFGH");
		send_message();

		// limit below the usual range
		set_max_header(16'd0);
		add_text("AB");
		add_byte(ChLf);
		add_text("Q");
		send_message();

		// limit reached by one long unterminated header
		set_max_header(16'd40);
		repeat (40) begin
			r = $urandom_range(32, 126);
			add_byte(r[7:0]);
		end
		send_message();
		add_line("Content-Length:4");
		add_crlf();
		add_random_bytes(4);
		send_message();

		set_max_header(MaxHdrReset);
		send_random_traffic(15, 1'b0);

		quiet = 1'b1;
		set_max_header(16'hFFFF);
		send_random_traffic(60, 1'b0);
		quiet = 1'b0;

		r = $urandom_range(20, 300);
		set_max_header(r[CntW-1:0]);
		send_random_traffic(20, 1'b1);

		set_max_header(16'd16);
		send_random_traffic(15, 1'b0);

		set_max_header(MaxHdrReset);
		send_random_traffic(20, 1'b1);

		// largest valid length; its body never completes, so it comes last
		add_line("Content-Length:2147483646");
		add_crlf();
		add_random_bytes(3);
		send_message();

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hrclf_pkg.sv
design/hrclf_parse.sv
design/http_response_content_length_framer.sv
design/hrclf_checker.sv
sim/framer_result_checker.sv
sim/http_response_content_length_framer_tb.sv
